// ----- sv/nrle_pkg.sv -----
// Shared types, constants and the run code function of the nibble RLE bit packer.
package nrle_pkg;

    localparam int MAX_RUN = 33;
    localparam int RUN_W   = 6;
    localparam int TALLY_W = 24;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // bit accumulator: up to 7 leftover bits plus two 10-bit codes
    localparam int ACC_W  = 27;
    localparam int ACC_NW = 5;

    // both queues
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [3:0] SINGLE_BITS = 4'd5;
    localparam logic [3:0] RUN_BITS    = 4'd10;

    typedef struct packed {
        logic [3:0] symbol;
        logic       final_symbol;
    } t_item;

    typedef struct packed {
        logic [7:0]         packed_byte;
        logic [3:0]         valid_bits;
        logic               stream_end;
        logic [TALLY_W-1:0] total_bits;
    } t_result;

    // one code request from front to back, right aligned bits
    typedef struct packed {
        logic [19:0] bits;
        logic [4:0]  nbits;
        logic        fin;
    } t_code;

    typedef struct packed {
        logic [9:0] code;
        logic [3:0] nbits;
    } t_rcode;

    function automatic t_rcode f_run_code(input logic [3:0] sym,
                                          input logic [RUN_W-1:0] len);
        t_rcode           r;
        logic [RUN_W-1:0] len_m2;
        len_m2 = len - RUN_W'(2);
        if (len <= RUN_W'(1)) begin
            r.code  = {5'd0, 1'b0, sym};
            r.nbits = SINGLE_BITS;
        end else begin
            r.code  = {1'b1, sym, len_m2[4:0]};
            r.nbits = RUN_BITS;
        end
        return r;
    endfunction

endpackage

// ----- sv/nrle_front.sv -----
// Front end: run tracking and code request generation.
module nrle_front import nrle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_q_full,
    output logic  o_full,
    output logic  o_wr,
    output t_code o_entry
);

    logic             r_open;
    logic [3:0]       r_sym;
    logic [RUN_W-1:0] r_len;

    logic             accept;
    logic             close;
    logic [3:0]       n_sym;
    logic [RUN_W-1:0] n_len;
    t_rcode           c1;
    t_rcode           c2;
    logic [19:0]      b1;
    logic [19:0]      b2;
    logic [3:0]       n1;
    logic [3:0]       n2;

    assign o_full = i_q_full;
    assign accept = i_push & ~i_q_full;

    always_comb begin
        close = 1'b0;
        n_sym = i_item.symbol;
        n_len = RUN_W'(1);
        if (r_open) begin
            if (i_item.symbol == r_sym && r_len < RUN_W'(MAX_RUN)) begin
                n_sym = r_sym;
                n_len = r_len + RUN_W'(1);
            end else begin
                close = 1'b1;
            end
        end
    end

    assign c1 = f_run_code(r_sym, r_len);
    assign c2 = f_run_code(n_sym, n_len);

    always_comb begin
        b1 = close ? {10'd0, c1.code} : '0;
        n1 = close ? c1.nbits : 4'd0;
        b2 = i_item.final_symbol ? {10'd0, c2.code} : '0;
        n2 = i_item.final_symbol ? c2.nbits : 4'd0;
        o_entry.bits  = (b1 << n2) | b2;
        o_entry.nbits = {1'b0, n1} + {1'b0, n2};
        o_entry.fin   = i_item.final_symbol;
    end

    assign o_wr = accept & (close | i_item.final_symbol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_sym  <= '0;
            r_len  <= '0;
        end else if (accept) begin
            if (i_item.final_symbol) begin
                r_open <= 1'b0;
                r_sym  <= '0;
                r_len  <= '0;
            end else begin
                r_open <= 1'b1;
                r_sym  <= n_sym;
                r_len  <= n_len;
            end
        end
    end

`ifndef SYNTHESIS
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_len != '0 && r_len <= RUN_W'(MAX_RUN)))
        else $error("open run has bad length");
`endif

endmodule

// ----- sv/nrle_code_q.sv -----
// Short queue of code requests between front and back.
module nrle_code_q import nrle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_code i_entry,
    output logic  o_full,
    output logic  o_vld,
    output t_code o_head,
    input  logic  i_rd
);

    t_code           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_full = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CW'(i_wr) - Q_CW'(i_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> r_cnt != '0)
        else $error("code queue read while empty");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt != Q_CW'(Q_DEPTH) || i_rd))
        else $error("code queue written while full");
`endif

endmodule

// ----- sv/nrle_back.sv -----
// Back end: bit accumulator, byte emission, tally and result queue.
module nrle_back import nrle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cq_vld,
    input  t_code   i_cq_head,
    output logic    o_cq_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic [ACC_W-1:0]   r_acc;
    logic [ACC_NW-1:0]  r_acc_n;
    logic               r_flush;
    logic [TALLY_W-1:0] r_tally;

    t_result            r_oq [Q_DEPTH];
    logic [Q_AW-1:0]    r_owp;
    logic [Q_AW-1:0]    r_orp;
    logic [Q_CW-1:0]    r_ocnt;

    logic               oq_full;
    logic               out_rd;
    logic               full_byte;
    logic               emit;
    logic               emit_last;
    logic [ACC_W-1:0]   sh_full;
    logic [ACC_W-1:0]   sh_part;
    t_result            res;
    logic [ACC_NW-1:0]  n_after;
    logic               flush_after;
    logic [TALLY_W-1:0] tally_after;
    logic               load;
    logic [TALLY_W:0]   tally_sum;

    assign oq_full   = (r_ocnt == Q_CW'(Q_DEPTH));
    assign o_empty   = (r_ocnt == '0);
    assign o_result  = r_oq[r_orp];
    assign out_rd    = i_pop & ~o_empty;

    assign full_byte = (r_acc_n >= ACC_NW'(8));
    assign emit      = ~oq_full & (full_byte | (r_flush & (r_acc_n != '0)));
    assign emit_last = emit & r_flush & (r_acc_n <= ACC_NW'(8));

    assign sh_full = r_acc >> (r_acc_n - ACC_NW'(8));
    assign sh_part = r_acc << (ACC_NW'(8) - r_acc_n);

    always_comb begin
        res.packed_byte = full_byte ? sh_full[7:0] : sh_part[7:0];
        res.valid_bits  = full_byte ? 4'd8 : r_acc_n[3:0];
        res.stream_end  = emit_last;
        res.total_bits  = emit_last ? r_tally : '0;
    end

    always_comb begin
        n_after = r_acc_n;
        if (emit) begin
            n_after = full_byte ? (r_acc_n - ACC_NW'(8)) : '0;
        end
    end

    assign flush_after = r_flush & ~emit_last;
    assign tally_after = emit_last ? '0 : r_tally;
    assign load        = i_cq_vld & ~flush_after & (n_after < ACC_NW'(8));
    assign o_cq_rd     = load;
    assign tally_sum   = {1'b0, tally_after} + (TALLY_W+1)'(i_cq_head.nbits);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc <= (r_acc << i_cq_head.nbits) | ACC_W'(i_cq_head.bits);
        end
        if (emit) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_n <= '0;
            r_flush <= 1'b0;
            r_tally <= '0;
            r_owp   <= '0;
            r_orp   <= '0;
            r_ocnt  <= '0;
        end else begin
            if (load) begin
                r_acc_n <= n_after + i_cq_head.nbits;
                r_flush <= i_cq_head.fin;
                r_tally <= tally_sum[TALLY_W] ? TALLY_MAX : tally_sum[TALLY_W-1:0];
            end else begin
                r_acc_n <= n_after;
                r_flush <= flush_after;
                r_tally <= tally_after;
            end
            if (emit) begin
                r_owp <= r_owp + Q_AW'(1);
            end
            if (out_rd) begin
                r_orp <= r_orp + Q_AW'(1);
            end
            r_ocnt <= r_ocnt + Q_CW'(emit) - Q_CW'(out_rd);
        end
    end

`ifndef SYNTHESIS
    a_acc_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_n <= ACC_NW'(ACC_W))
        else $error("accumulator overrun");
    a_flush_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_acc_n != '0)
        else $error("flush pending with no bits");
`endif

endmodule

// ----- sv/nibble_rle_bit_packer.sv -----
// Top level of the nibble RLE bit packer: front, code queue and back.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  input    | in  | push / full          | i_item   (symbol, final_symbol)
//  result   | out | empty / pop          | o_result (packed_byte, valid_bits,
//           |     |                      |           stream_end, total_bits)
//
//  One symbol is taken per cycle while full is low; full rises only when the
//  4-entry code queue between front and back is full.
//  The back end emits up to one byte per cycle unless the result queue is full, and
//  loads one code request per cycle while under 8 bits wait and no flush
//  is pending; requests pass the code queue, accumulator and result queue.
//  A result waiting in the 4-entry result queue does not stop intake until
//  both queues back up.
//  Synchronous active-low reset clears run state, accumulator bit count,
//  tally and queue pointers; accumulator and queue contents are not reset.
module nibble_rle_bit_packer import nrle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic  cq_full;
    logic  cq_wr;
    t_code cq_in;
    logic  cq_vld;
    t_code cq_head;
    logic  cq_rd;

    // front: tracks the open run, turns closed and final runs into code requests
    nrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (cq_full),
        .o_full   (full),
        .o_wr     (cq_wr),
        .o_entry  (cq_in)
    );

    // decouples symbol intake from byte emission
    nrle_code_q u_code_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cq_wr),
        .i_entry (cq_in),
        .o_full  (cq_full),
        .o_vld   (cq_vld),
        .o_head  (cq_head),
        .i_rd    (cq_rd)
    );

    // back: packs code bits MSB-first, flushes the last byte with the tally
    nrle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cq_vld  (cq_vld),
        .i_cq_head (cq_head),
        .o_cq_rd   (cq_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
